// ===== rtl/vsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsd_pkg
// Shared types and fixed constants of the variant set distance unit.
// ----------------------------------------------------------------------------
package vsd_pkg;

    // Fixed field widths of the item and result ports.
    localparam int CMD_W     = 3;
    localparam int RANGE_W   = 31;
    localparam int VCODE_W   = 16;
    localparam int RATIO_W   = 36;
    localparam int FRAC_BITS = 16;
    localparam int OVL_W     = RANGE_W + 1;

    // Command codes carried by an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN_REF = 3'd0,
        CMD_REF_CODE  = 3'd1,
        CMD_BEGIN_CMP = 3'd2,
        CMD_CMP_CODE  = 3'd3,
        CMD_FINISH    = 3'd4
    } vsd_cmd_t;

    // Top level sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_FIN_RANGE,
        ST_FIN_CHECK,
        ST_DIVIDE,
        ST_EMIT
    } vsd_state_t;

    // Status returned by the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } vsd_div_stat_t;

endpackage : vsd_pkg
`default_nettype wire

// ===== rtl/vsd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module vsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : vsd_ram
`default_nettype wire

// ===== rtl/vsd_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsd_div
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vsd_div #(
    parameter int N_W = 36,
    parameter int D_W = 32
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic      [N_W-1:0] quotient,
    output vsd_pkg::vsd_div_stat_t stat
);
    import vsd_pkg::*;

    localparam int CntW = $clog2(N_W + 1);

    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [N_W-1:0]  quo_reg, quo_next;
    logic [D_W-1:0]  rem_reg, rem_next;
    logic [D_W-1:0]  dvs_reg, dvs_next;
    logic [D_W:0]    trial;
    logic [D_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[N_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next  = CntW'(N_W);
            busy_next = 1'b1;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The remainder always stays below the divisor, so the
            // difference fits back into the remainder width.
            if (!diff[D_W])
            begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule : vsd_div
`default_nettype wire

// ===== rtl/variant_set_distance_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// variant_set_distance_unit
// Symmetric difference distance between a reference and a comparison code set.
// ----------------------------------------------------------------------------
// Items arrive on the in_valid/in_ready channel; each carries a command with
// a range or a variant code. Begin, reference code and comparison code items
// are taken back to back. A comparison code reads the tag memory and settles
// the miss counter in the following cycle, so a finish item straight after one
// waits for that update. Marking a reference code is one write to the memory.
// A finish item keeps in_ready low until its result sits in the output
// register: it passes the range and check states, in ratio mode with an
// overlap also the divide state of the bit-serial divider, then the emit state.
// The result is held on out_valid until out_ready takes it; other items are
// still accepted meanwhile, but a further finish waits for the slot to free.
// After reset the tag memory is swept to all ones, one entry per cycle, so
// in_ready stays low until every entry is written. The count_mode register may
// be written at any time through cfg_wr_en, also during the sweep.
// ----------------------------------------------------------------------------
module variant_set_distance_unit #(
    parameter int CODE_BITS  = 16,
    parameter int EPOCH_BITS = 16,
    parameter int COUNT_BITS = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [vsd_pkg::CMD_W-1:0]     cmd,
    input  wire logic [vsd_pkg::RANGE_W-1:0]   range_start,
    input  wire logic [vsd_pkg::RANGE_W-1:0]   range_end,
    input  wire logic [vsd_pkg::VCODE_W-1:0]   variant_code,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               no_overlap,
    output logic [COUNT_BITS-1:0]              miss_count,
    output logic [vsd_pkg::RATIO_W-1:0]        miss_ratio,
    output logic                               error
);
    import vsd_pkg::*;

    localparam int AccW  = COUNT_BITS + 2;
    localparam int DivNW = COUNT_BITS + FRAC_BITS;
    localparam logic [EPOCH_BITS-1:0] EpochAll = {EPOCH_BITS{1'b1}};
    localparam logic [AccW-1:0] AccMax = {2'b00, {COUNT_BITS{1'b1}}} |
                                         {2'b01, {COUNT_BITS{1'b0}}};
    localparam logic [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

    vsd_state_t state_reg, state_next;

    logic [CODE_BITS-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                  mode_reg;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [RANGE_W-1:0]    ref_start_reg, ref_start_next, ref_end_reg, ref_end_next;
    logic [RANGE_W-1:0]    cmp_start_reg, cmp_start_next, cmp_end_reg, cmp_end_next;
    logic [COUNT_BITS-1:0] ref_size_reg, ref_size_next;
    logic [AccW-1:0]       acc_reg, acc_next;
    logic                  sticky_reg, sticky_next;
    logic                  pend_reg, pend_next;
    logic [RANGE_W-1:0]    lo_reg, lo_next, hi_reg, hi_next;

    logic                  res_novl_reg, res_novl_next;
    logic [COUNT_BITS-1:0] res_miss_reg, res_miss_next;
    logic [RATIO_W-1:0]    res_ratio_reg, res_ratio_next;
    logic                  res_err_reg, res_err_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_novl_reg, out_novl_next;
    logic [COUNT_BITS-1:0] out_miss_reg, out_miss_next;
    logic [RATIO_W-1:0]    out_ratio_reg, out_ratio_next;
    logic                  out_err_reg, out_err_next;

    // Tag memory ports.
    logic                  mem_we, mem_re;
    logic [CODE_BITS-1:0]  mem_waddr;
    logic [EPOCH_BITS-1:0] mem_wdata, mem_rdata;

    // Divider.
    logic                  div_start;
    logic [DivNW-1:0]      div_dividend, div_quotient;
    logic [OVL_W-1:0]      overlap;
    vsd_div_stat_t         div_stat;

    logic                  accept;
    logic [CODE_BITS+VCODE_W-1:0] code_wide;
    logic [CODE_BITS-1:0]  code;
    logic                  acc_neg, acc_big;
    logic [COUNT_BITS-1:0] miss_clamped;
    logic [DivNW+RATIO_W-1:0] quo_ext;

    vsd_ram #(
        .WIDTH (EPOCH_BITS),
        .DEPTH (2 ** CODE_BITS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (code),
        .rd_data (mem_rdata)
    );

    vsd_div #(
        .N_W (DivNW),
        .D_W (OVL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (overlap),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // The code is taken modulo the store depth, zero-extended if wider.
    assign code_wide = {{CODE_BITS{1'b0}}, variant_code};
    assign code      = code_wide[CODE_BITS-1:0];

    // Overlap is worked out from the registered bounds, miss clamping from the registered counter.
    assign overlap      = {1'b0, hi_reg} - {1'b0, lo_reg} + OVL_W'(1);
    assign acc_neg      = acc_reg[AccW-1];
    assign acc_big      = !acc_reg[AccW-1] && acc_reg[COUNT_BITS];
    assign miss_clamped = acc_neg ? '0 : (acc_big ? '1 : acc_reg[COUNT_BITS-1:0]);
    assign div_dividend = {miss_clamped, {FRAC_BITS{1'b0}}};
    assign quo_ext      = {{RATIO_W{1'b0}}, div_quotient};

    // A finish straight after a comparison code waits for its counter update.
    assign in_ready = (state_reg == ST_RUN) && !(pend_reg && cmd == CMD_FINISH);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        epoch_next     = epoch_reg;
        ref_start_next = ref_start_reg;
        ref_end_next   = ref_end_reg;
        cmp_start_next = cmp_start_reg;
        cmp_end_next   = cmp_end_reg;
        ref_size_next  = ref_size_reg;
        acc_next       = acc_reg;
        sticky_next    = sticky_reg;
        pend_next      = 1'b0;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_novl_next  = res_novl_reg;
        res_miss_next  = res_miss_reg;
        res_ratio_next = res_ratio_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_novl_next  = out_novl_reg;
        out_miss_next  = out_miss_reg;
        out_ratio_next = out_ratio_reg;
        out_err_next   = out_err_reg;
        mem_we         = 1'b0;
        mem_waddr      = code;
        mem_wdata      = epoch_reg;
        mem_re         = 1'b0;
        div_start      = 1'b0;

        // Settle the comparison code read in the previous cycle.
        if (pend_reg)
        begin
            if (mem_rdata == epoch_reg)
            begin
                if (acc_reg == AccMin)
                begin
                    sticky_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_reg - AccW'(1);
                end
            end
            else
            begin
                if (acc_reg == AccMax)
                begin
                    sticky_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_reg + AccW'(1);
                end
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = EpochAll;
                clr_cnt_next = clr_cnt_reg + CODE_BITS'(1);
                if (clr_cnt_reg == {CODE_BITS{1'b1}})
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_BEGIN_REF:
                        begin
                            ref_start_next = range_start;
                            ref_end_next   = range_end;
                            ref_size_next  = '0;
                            if (epoch_reg == EpochAll - EPOCH_BITS'(1))
                            begin
                                sticky_next = 1'b1;
                            end
                            else
                            begin
                                epoch_next = epoch_reg + EPOCH_BITS'(1);
                            end
                        end
                        CMD_REF_CODE:
                        begin
                            mem_we = 1'b1;
                            if (ref_size_reg == {COUNT_BITS{1'b1}})
                            begin
                                sticky_next = 1'b1;
                            end
                            else
                            begin
                                ref_size_next = ref_size_reg + COUNT_BITS'(1);
                            end
                        end
                        CMD_BEGIN_CMP:
                        begin
                            cmp_start_next = range_start;
                            cmp_end_next   = range_end;
                            acc_next       = {2'b00, ref_size_reg};
                        end
                        CMD_CMP_CODE:
                        begin
                            mem_re    = 1'b1;
                            pend_next = 1'b1;
                        end
                        CMD_FINISH:
                        begin
                            state_next = ST_FIN_RANGE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FIN_RANGE:
            begin
                lo_next    = (ref_start_reg > cmp_start_reg) ? ref_start_reg : cmp_start_reg;
                hi_next    = (ref_end_reg < cmp_end_reg) ? ref_end_reg : cmp_end_reg;
                state_next = ST_FIN_CHECK;
            end
            ST_FIN_CHECK:
            begin
                if (hi_reg < lo_reg)
                begin
                    // Disjoint ranges: flag only, nothing is checked.
                    res_novl_next  = 1'b1;
                    res_miss_next  = '0;
                    res_ratio_next = '0;
                    res_err_next   = sticky_reg;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    res_novl_next  = 1'b0;
                    res_miss_next  = miss_clamped;
                    res_ratio_next = '0;
                    res_err_next   = sticky_reg || acc_neg || acc_big;
                    sticky_next    = sticky_reg || acc_neg || acc_big;
                    if (mode_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    // Saturate the quotient to the Q20.16 result width.
                    if (quo_ext[DivNW+RATIO_W-1:RATIO_W] != '0)
                    begin
                        res_ratio_next = '1;
                    end
                    else
                    begin
                        res_ratio_next = quo_ext[RATIO_W-1:0];
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_novl_next  = res_novl_reg;
                    out_miss_next  = res_miss_reg;
                    out_ratio_next = res_ratio_reg;
                    out_err_next   = res_err_reg;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            mode_reg      <= 1'b1;
            epoch_reg     <= EpochAll;
            ref_start_reg <= '0;
            ref_end_reg   <= '0;
            cmp_start_reg <= '0;
            cmp_end_reg   <= '0;
            ref_size_reg  <= '0;
            acc_reg       <= '0;
            sticky_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            epoch_reg     <= epoch_next;
            ref_start_reg <= ref_start_next;
            ref_end_reg   <= ref_end_next;
            cmp_start_reg <= cmp_start_next;
            cmp_end_reg   <= cmp_end_next;
            ref_size_reg  <= ref_size_next;
            acc_reg       <= acc_next;
            sticky_reg    <= sticky_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        res_novl_reg  <= res_novl_next;
        res_miss_reg  <= res_miss_next;
        res_ratio_reg <= res_ratio_next;
        res_err_reg   <= res_err_next;
        out_novl_reg  <= out_novl_next;
        out_miss_reg  <= out_miss_next;
        out_ratio_reg <= out_ratio_next;
        out_err_reg   <= out_err_next;
    end

    assign out_valid  = out_valid_reg;
    assign no_overlap = out_novl_reg;
    assign miss_count = out_miss_reg;
    assign miss_ratio = out_ratio_reg;
    assign error      = out_err_reg;

`ifndef NO_ASSERTIONS
    // A pending counter update always stems from a comparison code item.
    a_pend_source: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(accept && cmd == CMD_CMP_CODE))
        else $error("pending compare without a comparison code item");

    // Once left, the all-ones epoch is never entered again.
    a_epoch_never_all: assert property (@(posedge clk) disable iff (!rst_n)
        (epoch_reg != EpochAll) |=> (epoch_reg != EpochAll))
        else $error("epoch returned to all ones");

    // The error flag is sticky.
    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sticky_reg |=> sticky_reg)
        else $error("sticky error cleared");

    // A finish item starts the finishing sequence with its counter settled.
    a_finish_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_FINISH) |-> (!pend_reg ##1 state_reg == ST_FIN_RANGE))
        else $error("finish item did not start the finishing sequence");
`endif

endmodule : variant_set_distance_unit
`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the variant set distance unit. A queue of read
// items (reference and comparison reads with their codes) is driven on the
// input channel, and every finish result is predicted by a bench-side copy
// of the tag store, epoch and miss counter, then checked field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vsd_pkg::*;

    localparam int CODE_BITS  = 16;
    localparam int EPOCH_BITS = 16;
    localparam int COUNT_BITS = 20;

    localparam longint COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
    localparam longint ACC_MAX   = (64'd1 << (COUNT_BITS + 1)) - 1;
    localparam longint ACC_MIN   = -ACC_MAX - 1;
    localparam longint RATIO_MAX = (64'd1 << RATIO_W) - 1;

    localparam logic [EPOCH_BITS-1:0] EPOCH_ALL = '1;
    localparam logic [RANGE_W-1:0]    RANGE_TOP = '1;

    // Command codes that the unit ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    // This comfortably covers the ratio divide and any code item still
    // settling in the counter.
    localparam int SETTLE_CYCLES   = 64;
    // The longest correct stretch without any handshake is the tag memory
    // sweep after reset; the limit is several times its length.
    localparam int WATCHDOG_LIMIT  = 250000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 85;

    typedef struct {
        logic [CMD_W-1:0]   op;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        logic [VCODE_W-1:0] code;
    } read_item_t;

    typedef struct {
        logic                  no_ovl;
        logic [COUNT_BITS-1:0] miss;
        logic [RATIO_W-1:0]    ratio;
        logic                  err;
    } distance_t;

    // ------------------------------------------------------------------
    // Signals of the unit. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic                  cfg_wr_data  = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      cmd          = '0;
    logic [RANGE_W-1:0]    range_start  = '0;
    logic [RANGE_W-1:0]    range_end    = '0;
    logic [VCODE_W-1:0]    variant_code = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  no_overlap;
    logic [COUNT_BITS-1:0] miss_count;
    logic [RATIO_W-1:0]    miss_ratio;
    logic                  error;

    variant_set_distance_unit #(
        .CODE_BITS  (CODE_BITS),
        .EPOCH_BITS (EPOCH_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .range_start  (range_start),
        .range_end    (range_end),
        .variant_code (variant_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .no_overlap   (no_overlap),
        .miss_count   (miss_count),
        .miss_ratio   (miss_ratio),
        .error        (error)
    );

    // ------------------------------------------------------------------
    // Bench-side copy of the unit's state. The tag store and epoch reset
    // to all ones, so codes seen before any begin match unmarked entries.
    // ------------------------------------------------------------------
    logic [EPOCH_BITS-1:0] tag_mem [0:(1 << CODE_BITS)-1] = '{default: '1};
    logic [EPOCH_BITS-1:0] cur_epoch  = '1;
    logic [RANGE_W-1:0]    ref_lo     = '0;
    logic [RANGE_W-1:0]    ref_hi     = '0;
    logic [RANGE_W-1:0]    cmp_lo     = '0;
    logic [RANGE_W-1:0]    cmp_hi     = '0;
    longint                ref_count  = 0;
    longint                miss_sum   = 0;
    logic                  err_sticky = 1'b0;
    logic                  count_only = 1'b1;

    distance_t  pending_distances [$];
    read_item_t read_items [$];

    // Bench bookkeeping.
    read_item_t tx_item;
    read_item_t seen_item;
    distance_t  want;
    logic       in_taken          = 1'b0;
    int         idle_cycles       = 0;
    int         mismatch_count    = 0;
    int         items_pushed      = 0;
    int         items_accepted    = 0;
    int         phase_count       = 0;
    int         tx_idle_pct       = 0;
    int         rx_stall_pct      = 0;
    int         hold_off_requests = 0;
    int         hold_offs_served  = 0;
    int         hold_left         = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Mismatch reporting: one line per failing field, and a running count.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        mismatch_count++;
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, exp_v, got_v);
    endtask

    // ------------------------------------------------------------------
    // Set distance prediction. Each accepted item moves the copied state on
    // exactly as the unit should; a finish item adds one expected result.
    // ------------------------------------------------------------------
    task automatic update_set_distance(input read_item_t it);
        longint    ovl;
        longint    top;
        longint    bottom;
        longint    miss;
        distance_t res;
        case (it.op)
            CMD_BEGIN_REF: begin
                ref_lo    = it.lo;
                ref_hi    = it.hi;
                ref_count = 0;
                // The epoch stops one short of all ones, so that it can
                // never again match an entry that was never marked.
                if (cur_epoch == EPOCH_ALL - 1'b1)
                    err_sticky = 1'b1;
                else
                    cur_epoch = cur_epoch + 1'b1;
            end
            CMD_REF_CODE: begin
                tag_mem[it.code[CODE_BITS-1:0]] = cur_epoch;
                if (ref_count >= COUNT_MAX)
                    err_sticky = 1'b1;
                else
                    ref_count++;
            end
            CMD_BEGIN_CMP: begin
                cmp_lo   = it.lo;
                cmp_hi   = it.hi;
                miss_sum = ref_count;
            end
            CMD_CMP_CODE: begin
                // A code marked in this reference leaves the difference,
                // any other code joins it.
                if (tag_mem[it.code[CODE_BITS-1:0]] == cur_epoch) begin
                    if (miss_sum <= ACC_MIN)
                        err_sticky = 1'b1;
                    else
                        miss_sum--;
                end
                else begin
                    if (miss_sum >= ACC_MAX)
                        err_sticky = 1'b1;
                    else
                        miss_sum++;
                end
            end
            CMD_FINISH: begin
                top    = (ref_hi < cmp_hi) ? longint'(ref_hi) : longint'(cmp_hi);
                bottom = (ref_lo > cmp_lo) ? longint'(ref_lo) : longint'(cmp_lo);
                ovl    = top - bottom + 1;
                res    = '{no_ovl: 1'b0, miss: '0, ratio: '0, err: 1'b0};
                if (ovl <= 0) begin
                    res.no_ovl = 1'b1;
                end
                else begin
                    miss = 0;
                    if (miss_sum < 0) begin
                        err_sticky = 1'b1;
                    end
                    else if (miss_sum > COUNT_MAX) begin
                        err_sticky = 1'b1;
                        miss       = COUNT_MAX;
                    end
                    else begin
                        miss = miss_sum;
                    end
                    res.miss = COUNT_BITS'(miss);
                    if (!count_only)
                        res.ratio = RATIO_W'(((miss << FRAC_BITS) / ovl > RATIO_MAX)
                                             ? RATIO_MAX : (miss << FRAC_BITS) / ovl);
                end
                res.err = err_sticky;
                pending_distances.push_back(res);
            end
            default: begin
                // Spare command codes are ignored by the unit.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input driver: a new item is offered at the falling edge once the
    // previous one has been taken, unless the sender idles this cycle.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            if (read_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                tx_item      = read_items.pop_front();
                in_valid     <= 1'b1;
                cmd          <= tx_item.op;
                range_start  <= tx_item.lo;
                range_end    <= tx_item.hi;
                variant_code <= tx_item.code;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request,
    // counted down here so that the sender keeps pushing into a full unit.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_off_requests != hold_offs_served) begin
            hold_offs_served = hold_off_requests;
            hold_left        = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, accepted items feed the prediction and
    // accepted results are compared with the oldest expected distance. The
    // watchdog counts edges at which neither channel moved.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_taken    = 1'b0;
            idle_cycles = 0;
        end
        else begin
            in_taken = in_valid && in_ready;
            if (in_taken) begin
                seen_item.op   = cmd;
                seen_item.lo   = range_start;
                seen_item.hi   = range_end;
                seen_item.code = variant_code;
                update_set_distance(seen_item);
                items_accepted++;
            end
            if (out_valid && out_ready) begin
                if (pending_distances.size() == 0) begin
                    report_mismatch("result with none expected", '0, 64'(miss_count));
                end
                else begin
                    want = pending_distances.pop_front();
                    if (no_overlap !== want.no_ovl)
                        report_mismatch("no_overlap", 64'(want.no_ovl), 64'(no_overlap));
                    if (miss_count !== want.miss)
                        report_mismatch("miss_count", 64'(want.miss), 64'(miss_count));
                    if (miss_ratio !== want.ratio)
                        report_mismatch("miss_ratio", 64'(want.ratio), 64'(miss_ratio));
                    if (error !== want.err)
                        report_mismatch("error", 64'(want.err), 64'(error));
                end
            end
            if (in_taken || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic logic [RANGE_W-1:0] any_pos();
        return RANGE_W'($urandom);
    endfunction

    function automatic logic [VCODE_W-1:0] any_code();
        return VCODE_W'($urandom);
    endfunction

    function automatic logic [RANGE_W-1:0] clip_pos(input longint v);
        if (v < 0)
            return '0;
        if (v > longint'(RANGE_TOP))
            return RANGE_TOP;
        return RANGE_W'(v);
    endfunction

    task automatic queue_item(input logic [CMD_W-1:0] op, input logic [RANGE_W-1:0] lo,
                              input logic [RANGE_W-1:0] hi, input logic [VCODE_W-1:0] code);
        read_item_t it;
        it.op   = op;
        it.lo   = lo;
        it.hi   = hi;
        it.code = code;
        read_items.push_back(it);
        items_pushed++;
        // Ignored commands do not count towards the size of a phase.
        if (op <= CMD_FINISH)
            phase_count++;
    endtask

    // Now and then a spare command slips in between real items.
    task automatic maybe_noise();
        if ($urandom_range(11) == 0)
            queue_item(CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)),
                       any_pos(), any_pos(), any_code());
    endtask

    // Mostly short ranges so that the ratio is large enough to mean
    // something; sometimes huge ones, ranges at either end, or reversed ones.
    task automatic pick_range(output logic [RANGE_W-1:0] lo, output logic [RANGE_W-1:0] hi);
        longint s;
        longint span;
        logic [RANGE_W-1:0] t;
        case ($urandom_range(7))
            0:       s = 0;
            1:       s = longint'(RANGE_TOP) - $urandom_range(300);
            default: s = any_pos();
        endcase
        span = ($urandom_range(3) != 0) ? longint'($urandom_range(299)) : longint'(any_pos());
        lo   = clip_pos(s);
        hi   = clip_pos(s + span);
        if ($urandom_range(15) == 0) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
    endtask

    // A comparison read usually lies near its reference, so that most
    // finishes overlap; a quarter are placed anywhere.
    task automatic pick_cmp_range(input logic [RANGE_W-1:0] rlo,
                                  output logic [RANGE_W-1:0] lo, output logic [RANGE_W-1:0] hi);
        longint s;
        if ($urandom_range(3) == 0) begin
            pick_range(lo, hi);
        end
        else begin
            s  = longint'(rlo) + longint'($urandom_range(600)) - 300;
            lo = clip_pos(s);
            hi = clip_pos(s + longint'($urandom_range(400)));
        end
    endtask

    // One reference read, then one or two comparison reads or a bare
    // finish. The comparison codes are distinct, so the miss counter never
    // goes negative here; that case is left to the closing phase.
    task automatic queue_read_pair();
        logic [RANGE_W-1:0] rlo;
        logic [RANGE_W-1:0] rhi;
        logic [RANGE_W-1:0] clo;
        logic [RANGE_W-1:0] chi;
        logic [VCODE_W-1:0] c;
        logic [VCODE_W-1:0] marked [$];
        logic [VCODE_W-1:0] probe [$];
        int                 n_ref;
        int                 n_cmp;
        int                 idx;
        pick_range(rlo, rhi);
        queue_item(CMD_BEGIN_REF, rlo, rhi, any_code());
        maybe_noise();
        n_ref = $urandom_range(8);
        for (int i = 0; i < n_ref; i++) begin
            // A repeated reference code counts twice but marks once.
            if (marked.size() != 0 && $urandom_range(5) == 0) begin
                c = marked[$urandom_range(marked.size() - 1)];
            end
            else begin
                c = any_code();
                marked.push_back(c);
            end
            queue_item(CMD_REF_CODE, any_pos(), any_pos(), c);
            maybe_noise();
        end
        // Broken sequence: a finish with no comparison behind it.
        if ($urandom_range(9) == 0) begin
            queue_item(CMD_FINISH, any_pos(), any_pos(), any_code());
            return;
        end
        n_cmp = $urandom_range(1, 2);
        for (int k = 0; k < n_cmp; k++) begin
            pick_cmp_range(rlo, clo, chi);
            queue_item(CMD_BEGIN_CMP, clo, chi, any_code());
            probe.delete();
            foreach (marked[j])
                if ($urandom_range(1) != 0)
                    probe.push_back(marked[j]);
            for (int j = $urandom_range(4); j > 0; j--)
                probe.push_back(any_code());
            while (probe.size() != 0) begin
                idx = $urandom_range(probe.size() - 1);
                queue_item(CMD_CMP_CODE, any_pos(), any_pos(), probe[idx]);
                probe.delete(idx);
                maybe_noise();
            end
            queue_item(CMD_FINISH, any_pos(), any_pos(), any_code());
            // A repeated finish must give the same answer again.
            if ($urandom_range(7) == 0)
                queue_item(CMD_FINISH, any_pos(), any_pos(), any_code());
        end
    endtask

    // Waits until every pushed item is taken and every distance has come
    // back, then lets the unit finish any code item still in its counter.
    task automatic wait_for_quiet();
        while (items_accepted != items_pushed || pending_distances.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count_mode(input logic mode);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        count_only  = mode;
    endtask

    task automatic run_random_phase(input logic mode, input int tx_pct, input int rx_pct,
                                    input bit with_hold_off);
        wait_for_quiet();
        set_count_mode(mode);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (with_hold_off)
            hold_off_requests++;
        phase_count = 0;
        while (phase_count < PHASE_ITEMS)
            queue_read_pair();
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The unit sweeps its tag memory first; the mode may be set meanwhile.
        set_count_mode(1'b1);

        // Codes before any begin: the reset epoch matches every unmarked
        // entry, so the comparison code cancels the reference code.
        queue_item(CMD_REF_CODE, '0, '0, '0);
        queue_item(CMD_BEGIN_CMP, '0, '0, '1);
        queue_item(CMD_CMP_CODE, '1, '1, '1);
        queue_item(CMD_FINISH, '0, '0, '0);
        queue_item(CMD_SPARE_FIRST, '1, '1, '1);
        queue_item(CMD_W'(CMD_SPARE_FIRST + 1'b1), '0, '1, '0);
        queue_item(CMD_SPARE_LAST, '1, '0, '1);
        // Widest reference, a single-position comparison at the top end.
        queue_item(CMD_BEGIN_REF, '0, RANGE_TOP, '0);
        queue_item(CMD_REF_CODE, RANGE_TOP, '0, '1);
        queue_item(CMD_REF_CODE, '0, RANGE_TOP, '0);
        queue_item(CMD_BEGIN_CMP, RANGE_TOP, RANGE_TOP, '0);
        queue_item(CMD_CMP_CODE, '0, '0, '1);
        queue_item(CMD_CMP_CODE, '0, '0, 16'h1234);
        queue_item(CMD_FINISH, '0, '0, '0);
        queue_item(CMD_FINISH, '1, '1, '1);
        // A reversed comparison range cannot overlap.
        queue_item(CMD_BEGIN_CMP, 31'd10, 31'd5, '0);
        queue_item(CMD_FINISH, '0, '0, '0);

        // Ratio mode: overlap of the whole range, of one position and of
        // sixteen positions.
        wait_for_quiet();
        set_count_mode(1'b0);
        queue_item(CMD_BEGIN_CMP, '0, RANGE_TOP, '0);
        queue_item(CMD_CMP_CODE, '0, '0, '0);
        queue_item(CMD_FINISH, '0, '0, '0);
        queue_item(CMD_BEGIN_CMP, RANGE_TOP, RANGE_TOP, '0);
        queue_item(CMD_CMP_CODE, '0, '0, 16'hAAAA);
        queue_item(CMD_CMP_CODE, '0, '0, 16'h5555);
        queue_item(CMD_FINISH, '0, '0, '0);
        queue_item(CMD_BEGIN_CMP, RANGE_TOP - 31'd15, RANGE_TOP, '0);
        queue_item(CMD_FINISH, '0, '0, '0);

        // Random reads under changing flow control. The receiver phase
        // opens with a long hold-off so the unit fills up and stalls.
        run_random_phase(1'b0, 0, 0, 1'b0);
        run_random_phase(1'b1, 59, 0, 1'b0);
        run_random_phase(1'b0, 0, 59, 1'b1);
        run_random_phase(1'b1, 59, 59, 1'b0);
        run_random_phase(1'b0, 6, 6, 1'b0);

        // Closing phase, where the sticky error gets set for good.
        wait_for_quiet();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // Negative count: one marked code is compared twice.
        queue_item(CMD_BEGIN_REF, 31'd100, 31'd200, '0);
        queue_item(CMD_REF_CODE, '0, '0, 16'h00F0);
        queue_item(CMD_BEGIN_CMP, 31'd150, 31'd250, '0);
        queue_item(CMD_CMP_CODE, '0, '0, 16'h00F0);
        queue_item(CMD_CMP_CODE, '0, '0, 16'h00F0);
        queue_item(CMD_FINISH, '0, '0, '0);
        // One more code joins the same reference and is matched on its own;
        // a fresh reference then leaves that older mark stale.
        queue_item(CMD_REF_CODE, '0, '0, 16'h0F0F);
        queue_item(CMD_BEGIN_CMP, 31'd7, 31'd70, '0);
        queue_item(CMD_CMP_CODE, '0, '0, 16'h0F0F);
        queue_item(CMD_FINISH, '0, '0, '0);
        queue_item(CMD_BEGIN_REF, '0, RANGE_TOP, '0);
        queue_item(CMD_REF_CODE, '0, '0, 16'h3C3C);
        queue_item(CMD_BEGIN_CMP, 31'd7, 31'd70, '0);
        queue_item(CMD_CMP_CODE, '0, '0, 16'h0F0F);
        queue_item(CMD_CMP_CODE, '0, '0, 16'h3C3C);
        queue_item(CMD_CMP_CODE, '0, '0, 16'h0001);
        queue_item(CMD_FINISH, '0, '0, '0);

        wait_for_quiet();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule : testbench

// ===== filelist.f =====
rtl/vsd_pkg.sv
rtl/vsd_ram.sv
rtl/vsd_div.sv
rtl/variant_set_distance_unit.sv
dv/testbench.sv
